/* design/qat_pkg.sv */
// ----------------------------------------------------------------------------
// qat_pkg
// Shared types and constants of the quote-aware tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package qat_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgDelimiter  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgKeepQuotes = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTokenLimit = 2'd2;

  localparam logic [7:0] DelimiterRst  = 8'd32;
  localparam logic       KeepQuotesRst = 1'b0;
  localparam logic [4:0] TokenLimitRst = 5'd16;

  localparam logic [7:0] LineMax   = 8'd255;
  localparam logic [4:0] MaxTokens = 5'd16;

  localparam logic [7:0] SquoteChar = 8'h27;
  localparam logic [7:0] DquoteChar = 8'h22;
  localparam logic [7:0] NulChar    = 8'h00;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
    logic       is_zero;
    logic       is_squote;
    logic       is_dquote;
    logic       is_delim;
  } item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [7:0] write_pos;
    logic       token_begins;
    logic       token_recorded;
    logic [3:0] token_number;
    logic [4:0] token_count;
    logic       is_terminator;
  } result_t;

  typedef struct packed {
    logic [7:0] delimiter;
    logic       keep_quotes;
    logic [4:0] token_limit;
  } cfg_t;

endpackage

`default_nettype wire

/* design/qat_if.sv */
// ----------------------------------------------------------------------------
// qat_if
// Handshake channels of the quote-aware tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

interface qat_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_line;
  modport source (output valid, output char_in, output end_of_line, input ready);
  modport sink   (input valid, input char_in, input end_of_line, output ready);
endinterface

interface qat_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic [7:0] write_pos;
  logic       token_begins;
  logic       token_recorded;
  logic [3:0] token_number;
  logic [4:0] token_count;
  logic       is_terminator;
  modport source (output valid, output char_out, output write_pos, output token_begins,
                  output token_recorded, output token_number, output token_count,
                  output is_terminator, input ready);
  modport sink   (input valid, input char_out, input write_pos, input token_begins,
                  input token_recorded, input token_number, input token_count,
                  input is_terminator, output ready);
endinterface

interface qat_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [qat_pkg::CfgIdxW-1:0] index;
  logic [7:0]                 data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/qat_front.sv */
// ----------------------------------------------------------------------------
// qat_front
// Accepts input characters and classifies them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_front (
  qat_in_if.sink          in_i,
  input  wire logic [7:0] delimiter_i,
  output qat_pkg::item_t  item_o,
  output logic            item_valid_o,
  input  wire logic       item_ready_i
);

  assign in_i.ready   = item_ready_i;
  assign item_valid_o = in_i.valid;

  always_comb begin
    item_o.char_in     = in_i.char_in;
    item_o.end_of_line = in_i.end_of_line;
    item_o.is_zero     = (in_i.char_in == qat_pkg::NulChar);
    item_o.is_squote   = (in_i.char_in == qat_pkg::SquoteChar);
    item_o.is_dquote   = (in_i.char_in == qat_pkg::DquoteChar);
    item_o.is_delim    = (in_i.char_in == delimiter_i);
  end

endmodule

`default_nettype wire

/* design/qat_queue.sv */
// ----------------------------------------------------------------------------
// qat_queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire qat_pkg::item_t  push_item_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output qat_pkg::item_t       pop_item_o
);

  qat_pkg::item_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

/* design/qat_back.sv */
// ----------------------------------------------------------------------------
// qat_back
// Tracks quote and token state and registers one result per kept character and per line end.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire qat_pkg::cfg_t   cfg_i,
  input  wire logic            item_valid_i,
  output logic                 item_ready_o,
  input  wire qat_pkg::item_t  item_i,
  output logic                 res_valid_o,
  input  wire logic            res_ready_i,
  output qat_pkg::result_t     res_o
);

  logic             sq_q, sq_d, dq_q, dq_d;
  logic             sqd_q, sqd_d, dqd_q, dqd_d;
  logic             inside_q, inside_d;
  logic [7:0]       last_q, last_d;
  logic [7:0]       pos_q, pos_d;
  logic [4:0]       tokens_q, tokens_d;
  logic [7:0]       chars_q, chars_d;
  logic             res_valid_q, res_valid_d;
  qat_pkg::result_t res_q, res_d;

  logic       pop, iq1, iq2, strip, begins, recorded, ends, inside_mid;
  logic [4:0] limit;

  assign item_ready_o = !res_valid_q || res_ready_i;
  assign pop          = item_valid_i && item_ready_o;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;
  assign limit        = (cfg_i.token_limit > qat_pkg::MaxTokens) ? qat_pkg::MaxTokens
                                                                  : cfg_i.token_limit;

  always_comb begin
    sq_d        = sq_q;
    dq_d        = dq_q;
    sqd_d       = sqd_q;
    dqd_d       = dqd_q;
    inside_d    = inside_q;
    last_d      = last_q;
    pos_d       = pos_q;
    tokens_d    = tokens_q;
    chars_d     = chars_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;

    sq_d  = sq_q ^ (item_i.is_squote && !dq_q);
    dq_d  = dq_q ^ (item_i.is_dquote && !sq_d);
    iq1   = sq_d || sqd_q;
    iq2   = dq_d || dqd_q;
    strip = !cfg_i.keep_quotes && ((item_i.is_squote && iq1) || (item_i.is_dquote && iq2));
    begins = !inside_q && !item_i.is_delim &&
             (pos_q == 8'd0 || last_q == cfg_i.delimiter || last_q == qat_pkg::NulChar);
    recorded   = begins && (tokens_q < limit);
    inside_mid = inside_q || begins;
    ends = inside_mid && !iq1 && !iq2 && item_i.is_delim && pos_q != 8'd0 &&
           last_q != cfg_i.delimiter;

    if (!pop) begin
      sq_d = sq_q;
      dq_d = dq_q;
    end else if (item_i.end_of_line) begin
      res_valid_d          = 1'b1;
      res_d.char_out       = qat_pkg::NulChar;
      res_d.write_pos      = pos_q;
      res_d.token_begins   = 1'b0;
      res_d.token_recorded = 1'b0;
      res_d.token_number   = 4'd0;
      res_d.token_count    = tokens_q;
      res_d.is_terminator  = 1'b1;
      sq_d     = 1'b0;
      dq_d     = 1'b0;
      sqd_d    = 1'b0;
      dqd_d    = 1'b0;
      inside_d = 1'b0;
      last_d   = 8'd0;
      pos_d    = 8'd0;
      tokens_d = 5'd0;
      chars_d  = 8'd0;
    end else if (item_i.is_zero || chars_q >= qat_pkg::LineMax) begin
      sq_d = sq_q;
      dq_d = dq_q;
    end else begin
      chars_d = chars_q + 8'd1;
      sqd_d   = sq_d;
      dqd_d   = dq_d;
      if (!strip) begin
        tokens_d = recorded ? tokens_q + 5'd1 : tokens_q;
        inside_d = inside_mid && !ends;
        last_d   = ends ? qat_pkg::NulChar : item_i.char_in;
        pos_d    = pos_q + 8'd1;
        res_valid_d          = 1'b1;
        res_d.char_out       = ends ? qat_pkg::NulChar : item_i.char_in;
        res_d.write_pos      = pos_q;
        res_d.token_begins   = begins;
        res_d.token_recorded = recorded;
        res_d.token_number   = recorded ? tokens_q[3:0] : 4'd0;
        res_d.token_count    = tokens_d;
        res_d.is_terminator  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q        <= 1'b0;
      dq_q        <= 1'b0;
      sqd_q       <= 1'b0;
      dqd_q       <= 1'b0;
      inside_q    <= 1'b0;
      last_q      <= 8'd0;
      pos_q       <= 8'd0;
      tokens_q    <= 5'd0;
      chars_q     <= 8'd0;
      res_valid_q <= 1'b0;
    end else begin
      sq_q        <= sq_d;
      dq_q        <= dq_d;
      sqd_q       <= sqd_d;
      dqd_q       <= dqd_d;
      inside_q    <= inside_d;
      last_q      <= last_d;
      pos_q       <= pos_d;
      tokens_q    <= tokens_d;
      chars_q     <= chars_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

endmodule

`default_nettype wire

/* design/quote_aware_tokenizer.sv */
// ----------------------------------------------------------------------------
// quote_aware_tokenizer
// Splits a text line into tokens at a configurable delimiter, honoring quotes.
// ----------------------------------------------------------------------------
// Characters arrive on in_i, one per transaction; a transaction with
// end_of_line set closes the line. Each kept character gives one transaction
// on out_o with the rewritten byte, its buffer position and token marks, and
// the end of a line gives the terminator with the token count. Zero bytes,
// stripped quotes and characters past the line length give no result.
// Registers are written through cfg_i, which is always ready; they may only
// change while the block is idle.
// A result passes first through the two-entry queue behind the front end,
// then through the back end's output register.
// With out_o ready the block takes one character every cycle. When out_o
// stalls, the back end holds its result and the queue fills, after which
// in_i drops ready until the receiver takes the result.
// Reset clears all line state and loads the registers with space as the
// delimiter, quote stripping, and a token limit of sixteen.
// ----------------------------------------------------------------------------
`default_nettype none

module quote_aware_tokenizer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qat_in_if.sink     in_i,
  qat_out_if.source  out_o,
  qat_cfg_if.sink    cfg_i
);

  qat_pkg::cfg_t    cfg_q, cfg_d;
  qat_pkg::item_t   front_item, back_item;
  qat_pkg::result_t res;
  logic             front_valid, front_ready, back_valid, back_ready;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        qat_pkg::CfgDelimiter:  cfg_d.delimiter   = cfg_i.data;
        qat_pkg::CfgKeepQuotes: cfg_d.keep_quotes = cfg_i.data[0];
        qat_pkg::CfgTokenLimit: cfg_d.token_limit = cfg_i.data[4:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delimiter   <= qat_pkg::DelimiterRst;
      cfg_q.keep_quotes <= qat_pkg::KeepQuotesRst;
      cfg_q.token_limit <= qat_pkg::TokenLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  qat_front u_front (
    .in_i         (in_i),
    .delimiter_i  (cfg_q.delimiter),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  qat_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_item_o   (back_item)
  );

  qat_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (back_valid),
    .item_ready_o (back_ready),
    .item_i       (back_item),
    .res_valid_o  (out_o.valid),
    .res_ready_i  (out_o.ready),
    .res_o        (res)
  );

  assign out_o.char_out       = res.char_out;
  assign out_o.write_pos      = res.write_pos;
  assign out_o.token_begins   = res.token_begins;
  assign out_o.token_recorded = res.token_recorded;
  assign out_o.token_number   = res.token_number;
  assign out_o.token_count    = res.token_count;
  assign out_o.is_terminator  = res.is_terminator;

endmodule

`default_nettype wire
